FILE: hdl/dof_pkg.sv
`timescale 1ns / 1ps
// Shared widths, stream payload layout and sideband types for the disk occluder
// form factor pipeline. No dependencies.
package dof_pkg;

    localparam int POS_W     = 32;
    localparam int NORM_W    = 18;
    localparam int RAD_W     = 31;
    localparam int EPS_W     = 16;
    localparam int FF_W      = 31;
    localparam int FRAC_W    = 16;

    localparam int D0_W      = POS_W + 1;
    localparam int T_W       = D0_W + NORM_W + 2;
    localparam int HP_W      = 31;
    localparam int D1_W      = D0_W + 1;
    localparam int NN_W      = 2 * NORM_W;
    localparam int RR_W      = 2 * HP_W + NN_W - 32;
    localparam int DOT_W     = D1_W + NORM_W + 2;
    localparam int MAG_W     = DOT_W - 1;
    localparam int DD_W      = 2 * D1_W;
    localparam int P_W       = 2 * MAG_W;
    localparam int C_W       = 64;
    localparam int DEN2_W    = DD_W + 1 + FRAC_W;
    localparam int NUM2_W    = 128;

    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 32;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
    localparam logic [FF_W-1:0]  FF_MAX    = '1;
    localparam logic             OP_LOAD   = 1'b0;
    localparam logic             OP_EVAL   = 1'b1;

    typedef struct packed {
        logic [S_TDATA_W-RAD_W-3*NORM_W-3*POS_W-1:0] pad;
        logic [RAD_W-1:0]         radius;
        logic signed [NORM_W-1:0] norm_z;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_x;
    } dof_in_t;

    typedef struct packed {
        logic              zero;
        logic [RR_W-1:0]   rr;
        logic [DEN2_W-1:0] den2;
    } dof_side_t;

    typedef struct packed {
        logic zero;
        logic c_ovf;
    } dof_flags_t;

endpackage

FILE: hdl/disk_occluder_form_factor.sv
`timescale 1ns / 1ps
// Disk occluder form factor: one result per occluder transaction, Q15.16 saturated.
// Depends on dof_pkg, dof_front, dof_div and dof_scale.
//
// A transaction with tuser = 0 loads the receiver point and normal and returns nothing;
// a transaction with tuser = 1 evaluates one disk occluder against the latest receiver
// and returns one form factor. One occluder is taken every cycle: ten geometry stages,
// a 65-stage bit-per-stage divider for the cosine quotient, two multiply stages, a
// 32-stage divider for the final quotient and the output register. The whole pipeline
// holds while a result waits on m_axis_tready.
// epsilon is written through cfg_wr_en/cfg_wr_data and resets to 1.
module disk_occluder_form_factor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dof_pkg::EPS_W-1:0]     cfg_wr_data,   // epsilon
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, radius, zero fill
    input  logic [dof_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dof_pkg::M_TDATA_W-1:0] m_axis_tdata   // form_factor, zero fill
);
    import dof_pkg::*;

    logic              en;
    logic              accept;
    logic [EPS_W-1:0]  eps_reg;
    dof_in_t           in_data;

    logic              f_valid;
    logic [P_W-1:0]    f_p;
    logic [DD_W-1:0]   f_dd;
    dof_side_t         f_side;

    logic              c_valid;
    logic [C_W-1:0]    c_quo;
    logic              c_ovf;
    dof_side_t         c_side;

    logic              s_valid;
    logic [NUM2_W-1:0] s_num;
    logic [DEN2_W-1:0] s_den2;
    dof_flags_t        s_flags;

    logic              q_valid;
    logic [FF_W-1:0]   q_quo;
    logic              q_ovf;
    dof_flags_t        q_flags;

    logic              out_valid_reg;
    logic [FF_W-1:0]   ff_reg;
    logic [FF_W-1:0]   ff_next;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign in_data       = s_axis_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            eps_reg <= cfg_wr_data;
        end
    end

    dof_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (accept),
        .in_op     (s_axis_tuser),
        .in_data   (in_data),
        .eps       (eps_reg),
        .out_valid (f_valid),
        .p_num     (f_p),
        .dd        (f_dd),
        .side      (f_side)
    );

    dof_div #(
        .NUM_W  (P_W),
        .DEN_W  (DD_W),
        .Q_W    (C_W),
        .SIDE_W ($bits(dof_side_t))
    ) u_div_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_p),
        .den       (f_dd),
        .side_in   (f_side),
        .out_valid (c_valid),
        .quo       (c_quo),
        .ovf       (c_ovf),
        .side_out  (c_side)
    );

    dof_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid),
        .c         (c_quo),
        .c_ovf     (c_ovf),
        .side      (c_side),
        .out_valid (s_valid),
        .num       (s_num),
        .den2      (s_den2),
        .flags     (s_flags)
    );

    dof_div #(
        .NUM_W  (NUM2_W),
        .DEN_W  (DEN2_W),
        .Q_W    (FF_W),
        .SIDE_W ($bits(dof_flags_t))
    ) u_div_ff (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .num       (s_num),
        .den       (s_den2),
        .side_in   (s_flags),
        .out_valid (q_valid),
        .quo       (q_quo),
        .ovf       (q_ovf),
        .side_out  (q_flags)
    );

    always_comb
    begin
        if (q_flags.zero)
        begin
            ff_next = '0;
        end
        else if (q_flags.c_ovf || q_ovf)
        begin
            ff_next = FF_MAX;
        end
        else
        begin
            ff_next = q_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ff_reg <= ff_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(ff_reg);

endmodule

FILE: hdl/dof_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// and sideband carried alongside. Depends on dof_pkg for default widths.
module dof_div #(
    parameter int NUM_W  = dof_pkg::P_W,
    parameter int DEN_W  = dof_pkg::DD_W,
    parameter int Q_W    = dof_pkg::C_W,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic              ovf,
    output logic [SIDE_W-1:0] side_out
);
    localparam int TOP_W = NUM_W - Q_W;
    localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

    logic [Q_W:0]        vld_reg;
    logic [DEN_W-1:0]    rem_reg  [Q_W+1];
    logic [Q_W-1:0]      low_reg  [Q_W+1];
    logic [Q_W-1:0]      q_reg    [Q_W+1];
    logic [DEN_W-1:0]    den_reg  [Q_W+1];
    logic                ovf_reg  [Q_W+1];
    logic [SIDE_W-1:0]   side_reg [Q_W+1];

    logic [DEN_W:0]      trial    [1:Q_W];
    logic [DEN_W:0]      diff     [1:Q_W];
    logic                ge       [1:Q_W];
    logic [DEN_W-1:0]    rem_next [1:Q_W];
    logic [CMP_W-1:0]    top_ext;
    logic [CMP_W-1:0]    den_ext;

    assign top_ext = CMP_W'(num[NUM_W-1:Q_W]);
    assign den_ext = CMP_W'(den);

    always_comb
    begin
        for (int k = 1; k <= Q_W; k++)
        begin
            trial[k]    = {rem_reg[k-1], low_reg[k-1][Q_W-1]};
            diff[k]     = trial[k] - {1'b0, den_reg[k-1]};
            ge[k]       = (trial[k] >= {1'b0, den_reg[k-1]});
            rem_next[k] = ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Q_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(num[NUM_W-1:Q_W]);
            low_reg[0]  <= num[Q_W-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= (top_ext >= den_ext);
            side_reg[0] <= side_in;
            for (int k = 1; k <= Q_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= {low_reg[k-1][Q_W-2:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][Q_W-2:0], ge[k]};
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quo       = q_reg[Q_W];
    assign ovf       = ovf_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

FILE: hdl/dof_front.sv
`timescale 1ns / 1ps
// Receiver registers and the ten-stage geometry front end: offsets, horizon
// clipping, dot products and the cosine product. Depends on dof_pkg.
module dof_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic                      in_op,
    input  dof_pkg::dof_in_t          in_data,
    input  logic [dof_pkg::EPS_W-1:0] eps,
    output logic                      out_valid,
    output logic [dof_pkg::P_W-1:0]   p_num,
    output logic [dof_pkg::DD_W-1:0]  dd,
    output dof_pkg::dof_side_t        side
);
    import dof_pkg::*;

    localparam int STAGES = 10;
    localparam int LO_W   = 27;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int TP_W   = D0_W + NORM_W;
    localparam int RSQ_W  = 2 * NORM_W - 1;
    localparam int ADJ_W  = HP_W + 1 + NORM_W;
    localparam int HM_W   = HP_W + NN_W;
    localparam int FULL_W = 2 * HP_W + NN_W;
    localparam int DP_W   = D1_W + NORM_W;
    localparam int SQ_W   = 2 * D1_W - 1;

    logic signed [POS_W-1:0]  rp_reg [3];
    logic signed [NORM_W-1:0] rn_reg [3];
    logic signed [POS_W-1:0]  pos    [3];
    logic signed [NORM_W-1:0] nrm    [3];
    logic [STAGES-1:0]        vld_reg;

    logic signed [D0_W-1:0]   s1_d0_reg [3];
    logic signed [NORM_W-1:0] s1_rn_reg [3];
    logic signed [NORM_W-1:0] s1_on_reg [3];
    logic [RAD_W-1:0]         s1_rad_reg;

    logic signed [TP_W-1:0]   s2_tp_reg  [3];
    logic [RSQ_W-1:0]         s2_rsq_reg [3];
    logic signed [D0_W-1:0]   s2_d0_reg  [3];
    logic signed [NORM_W-1:0] s2_rn_reg  [3];
    logic signed [NORM_W-1:0] s2_on_reg  [3];
    logic [RAD_W-1:0]         s2_rad_reg;

    logic signed [T_W-1:0]    s3_t_reg;
    logic [NN_W-1:0]          s3_nn_reg;
    logic signed [D0_W-1:0]   s3_d0_reg [3];
    logic signed [NORM_W-1:0] s3_rn_reg [3];
    logic signed [NORM_W-1:0] s3_on_reg [3];
    logic [RAD_W-1:0]         s3_rad_reg;

    logic                     s4_below_reg;
    logic                     s4_strad_reg;
    logic [HP_W-1:0]          s4_half_reg;
    logic [HP_W-1:0]          s4_hp_reg;
    logic [NN_W-1:0]          s4_nn_reg;
    logic signed [D0_W-1:0]   s4_d0_reg [3];
    logic signed [NORM_W-1:0] s4_rn_reg [3];
    logic signed [NORM_W-1:0] s4_on_reg [3];
    logic [RAD_W-1:0]         s4_rad_reg;

    logic signed [ADJ_W-1:0]  s5_adj_reg [3];
    logic [2*HP_W-1:0]        s5_hp2_reg;
    logic [2*RAD_W-1:0]       s5_rad2_reg;
    logic                     s5_below_reg;
    logic                     s5_strad_reg;
    logic [NN_W-1:0]          s5_nn_reg;
    logic signed [D0_W-1:0]   s5_d0_reg [3];
    logic signed [NORM_W-1:0] s5_rn_reg [3];
    logic signed [NORM_W-1:0] s5_on_reg [3];

    logic signed [D1_W-1:0]   s6_d1_reg [3];
    logic [HM_W-1:0]          s6_hlo_reg;
    logic [HM_W-1:0]          s6_hhi_reg;
    logic [2*RAD_W-1:0]       s6_rad2_reg;
    logic                     s6_below_reg;
    logic                     s6_strad_reg;
    logic signed [NORM_W-1:0] s6_rn_reg [3];
    logic signed [NORM_W-1:0] s6_on_reg [3];

    logic signed [DP_W-1:0]   s7_ddop_reg [3];
    logic signed [DP_W-1:0]   s7_ddnp_reg [3];
    logic [SQ_W-1:0]          s7_sq_reg   [3];
    logic [RR_W-1:0]          s7_rr_reg;
    logic                     s7_below_reg;

    logic signed [DOT_W-1:0]  s8_ddo_reg;
    logic signed [DOT_W-1:0]  s8_ddn_reg;
    logic [DD_W-1:0]          s8_dd_reg;
    logic [RR_W-1:0]          s8_rr_reg;
    logic                     s8_below_reg;

    logic                     s9_zero_reg;
    logic [2*LO_W-1:0]        s9_pll_reg;
    logic [LO_W+HI_W-1:0]     s9_plh_reg;
    logic [LO_W+HI_W-1:0]     s9_phl_reg;
    logic [2*HI_W-1:0]        s9_phh_reg;
    logic [DD_W-1:0]          s9_dd_reg;
    logic [RR_W-1:0]          s9_rr_reg;
    logic [DEN2_W-1:0]        s9_den2_reg;

    logic [P_W-1:0]           s10_p_reg;
    logic [DD_W-1:0]          s10_dd_reg;
    dof_side_t                s10_side_reg;

    logic signed [T_W:0]      big_r;
    logic signed [T_W:0]      r_minus_t;
    logic signed [T_W:0]      r_plus_t;
    logic [FULL_W-1:0]        rr_full;
    logic signed [2*D1_W-1:0] sq_full [3];
    logic signed [DOT_W-1:0]  ddo_neg;
    logic [MAG_W-1:0]         mag_o;
    logic [MAG_W-1:0]         mag_n;
    logic [DD_W:0]            den_sum;

    always_comb
    begin
        pos[0] = in_data.pos_x;
        pos[1] = in_data.pos_y;
        pos[2] = in_data.pos_z;
        nrm[0] = in_data.norm_x;
        nrm[1] = in_data.norm_y;
        nrm[2] = in_data.norm_z;
    end

    assign big_r     = $signed((T_W+1)'({s3_rad_reg, {FRAC_W{1'b0}}}));
    assign r_minus_t = big_r - (T_W+1)'(s3_t_reg);
    assign r_plus_t  = big_r + (T_W+1)'(s3_t_reg);
    assign rr_full   = {s6_hhi_reg, {HP_W{1'b0}}} + FULL_W'(s6_hlo_reg);
    assign ddo_neg   = -s8_ddo_reg;
    assign mag_o     = ddo_neg[MAG_W-1:0];
    assign mag_n     = s8_ddn_reg[MAG_W-1:0];
    assign den_sum   = (DD_W+1)'(s8_dd_reg) + (DD_W+1)'({eps, {FRAC_W{1'b0}}});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i] = s6_d1_reg[i] * s6_d1_reg[i];
        end
    end

    // receiver load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rp_reg[i] <= '0;
                rn_reg[i] <= '0;
            end
        end
        else if (in_valid && in_op == OP_LOAD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rp_reg[i] <= pos[i];
                rn_reg[i] <= nrm[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid && in_op != OP_LOAD};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_d0_reg[i]   <= D0_W'(pos[i]) - D0_W'(rp_reg[i]);
                s1_rn_reg[i]   <= rn_reg[i];
                s1_on_reg[i]   <= nrm[i];

                s2_tp_reg[i]   <= s1_d0_reg[i] * s1_rn_reg[i];
                s2_rsq_reg[i]  <= RSQ_W'(s1_rn_reg[i] * s1_rn_reg[i]);
                s2_d0_reg[i]   <= s1_d0_reg[i];
                s2_rn_reg[i]   <= s1_rn_reg[i];
                s2_on_reg[i]   <= s1_on_reg[i];

                s3_d0_reg[i]   <= s2_d0_reg[i];
                s3_rn_reg[i]   <= s2_rn_reg[i];
                s3_on_reg[i]   <= s2_on_reg[i];

                s4_d0_reg[i]   <= s3_d0_reg[i];
                s4_rn_reg[i]   <= s3_rn_reg[i];
                s4_on_reg[i]   <= s3_on_reg[i];

                s5_adj_reg[i]  <= $signed({1'b0, s4_half_reg}) * s4_rn_reg[i];
                s5_d0_reg[i]   <= s4_d0_reg[i];
                s5_rn_reg[i]   <= s4_rn_reg[i];
                s5_on_reg[i]   <= s4_on_reg[i];

                s6_d1_reg[i]   <= D1_W'(s5_d0_reg[i])
                                + (s5_strad_reg ? $signed(s5_adj_reg[i][ADJ_W-1:FRAC_W])
                                                : D1_W'(0));
                s6_rn_reg[i]   <= s5_rn_reg[i];
                s6_on_reg[i]   <= s5_on_reg[i];

                s7_ddop_reg[i] <= s6_d1_reg[i] * s6_on_reg[i];
                s7_ddnp_reg[i] <= s6_d1_reg[i] * s6_rn_reg[i];
                s7_sq_reg[i]   <= sq_full[i][SQ_W-1:0];
            end
            s1_rad_reg   <= in_data.radius;

            s2_rad_reg   <= s1_rad_reg;

            s3_t_reg     <= T_W'(s2_tp_reg[0]) + T_W'(s2_tp_reg[1]) + T_W'(s2_tp_reg[2]);
            s3_nn_reg    <= NN_W'(s2_rsq_reg[0]) + NN_W'(s2_rsq_reg[1])
                          + NN_W'(s2_rsq_reg[2]);
            s3_rad_reg   <= s2_rad_reg;

            s4_below_reg <= r_plus_t[T_W];
            s4_strad_reg <= !r_minus_t[T_W] && (r_minus_t != '0);
            s4_half_reg  <= r_minus_t[FRAC_W+HP_W:FRAC_W+1];
            s4_hp_reg    <= r_plus_t[FRAC_W+HP_W:FRAC_W+1];
            s4_nn_reg    <= s3_nn_reg;
            s4_rad_reg   <= s3_rad_reg;

            s5_hp2_reg   <= s4_hp_reg * s4_hp_reg;
            s5_rad2_reg  <= s4_rad_reg * s4_rad_reg;
            s5_below_reg <= s4_below_reg;
            s5_strad_reg <= s4_strad_reg;
            s5_nn_reg    <= s4_nn_reg;

            s6_hlo_reg   <= s5_hp2_reg[HP_W-1:0] * s5_nn_reg;
            s6_hhi_reg   <= s5_hp2_reg[2*HP_W-1:HP_W] * s5_nn_reg;
            s6_rad2_reg  <= s5_rad2_reg;
            s6_below_reg <= s5_below_reg;
            s6_strad_reg <= s5_strad_reg;

            s7_rr_reg    <= s6_strad_reg ? rr_full[FULL_W-1:FULL_W-RR_W]
                                         : RR_W'(s6_rad2_reg);
            s7_below_reg <= s6_below_reg;

            s8_ddo_reg   <= DOT_W'(s7_ddop_reg[0]) + DOT_W'(s7_ddop_reg[1])
                          + DOT_W'(s7_ddop_reg[2]);
            s8_ddn_reg   <= DOT_W'(s7_ddnp_reg[0]) + DOT_W'(s7_ddnp_reg[1])
                          + DOT_W'(s7_ddnp_reg[2]);
            s8_dd_reg    <= DD_W'(s7_sq_reg[0]) + DD_W'(s7_sq_reg[1]) + DD_W'(s7_sq_reg[2]);
            s8_rr_reg    <= s7_rr_reg;
            s8_below_reg <= s7_below_reg;

            s9_zero_reg  <= s8_below_reg || !s8_ddo_reg[DOT_W-1]
                          || s8_ddn_reg[DOT_W-1] || (s8_ddn_reg == '0);
            s9_pll_reg   <= mag_o[LO_W-1:0] * mag_n[LO_W-1:0];
            s9_plh_reg   <= mag_o[LO_W-1:0] * mag_n[MAG_W-1:LO_W];
            s9_phl_reg   <= mag_o[MAG_W-1:LO_W] * mag_n[LO_W-1:0];
            s9_phh_reg   <= mag_o[MAG_W-1:LO_W] * mag_n[MAG_W-1:LO_W];
            s9_dd_reg    <= s8_dd_reg;
            s9_rr_reg    <= s8_rr_reg;
            s9_den2_reg  <= {den_sum, {FRAC_W{1'b0}}};

            s10_p_reg    <= (P_W'(s9_phh_reg) << (2 * LO_W))
                          + ((P_W'(s9_plh_reg) + P_W'(s9_phl_reg)) << LO_W)
                          + P_W'(s9_pll_reg);
            s10_dd_reg        <= s9_dd_reg;
            s10_side_reg.zero <= s9_zero_reg;
            s10_side_reg.rr   <= s9_rr_reg;
            s10_side_reg.den2 <= s9_den2_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign p_num     = s10_p_reg;
    assign dd        = s10_dd_reg;
    assign side      = s10_side_reg;

endmodule

FILE: hdl/dof_scale.sv
`timescale 1ns / 1ps
// Two-stage 66 x 64 multiplier that scales the cosine quotient by the squared
// radius, modulo 2^128. Depends on dof_pkg.
module dof_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [dof_pkg::C_W-1:0]    c,
    input  logic                       c_ovf,
    input  dof_pkg::dof_side_t         side,
    output logic                       out_valid,
    output logic [dof_pkg::NUM2_W-1:0] num,
    output logic [dof_pkg::DEN2_W-1:0] den2,
    output dof_pkg::dof_flags_t        flags
);
    import dof_pkg::*;

    localparam int HW = 32;
    localparam int R2_W = RR_W - 2 * HW;

    logic [1:0]          vld_reg;
    logic [2*HW-1:0]     p00_reg;
    logic [2*HW-1:0]     p01_reg;
    logic [2*HW-1:0]     p10_reg;
    logic [2*HW-1:0]     p11_reg;
    logic [R2_W+HW-1:0]  p20_reg;
    logic [R2_W+HW-1:0]  p21_reg;
    logic [DEN2_W-1:0]   m1_den2_reg;
    dof_flags_t          m1_flags_reg;
    logic [NUM2_W-1:0]   num_reg;
    logic [DEN2_W-1:0]   den2_reg;
    dof_flags_t          flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg            <= side.rr[HW-1:0] * c[HW-1:0];
            p01_reg            <= side.rr[HW-1:0] * c[2*HW-1:HW];
            p10_reg            <= side.rr[2*HW-1:HW] * c[HW-1:0];
            p11_reg            <= side.rr[2*HW-1:HW] * c[2*HW-1:HW];
            p20_reg            <= side.rr[RR_W-1:2*HW] * c[HW-1:0];
            p21_reg            <= side.rr[RR_W-1:2*HW] * c[2*HW-1:HW];
            m1_den2_reg        <= side.den2;
            m1_flags_reg.zero  <= side.zero;
            m1_flags_reg.c_ovf <= c_ovf;

            num_reg   <= NUM2_W'(p00_reg)
                       + (NUM2_W'(p01_reg) << HW)
                       + (NUM2_W'(p10_reg) << HW)
                       + (NUM2_W'(p11_reg) << (2 * HW))
                       + (NUM2_W'(p20_reg) << (2 * HW))
                       + (NUM2_W'(p21_reg) << (3 * HW));
            den2_reg  <= m1_den2_reg;
            flags_reg <= m1_flags_reg;
        end
    end

    assign out_valid = vld_reg[1];
    assign num       = num_reg;
    assign den2      = den2_reg;
    assign flags     = flags_reg;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for disk_occluder_form_factor: directed table, then random receivers
// and occluders over several epsilon settings and idle patterns. Depends on dof_pkg.
module tb_top;
    import dof_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 70;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic       op;
        dof_in_t    geo;
        bit         known;
        logic [FF_W-1:0] ff;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [EPS_W-1:0] cfg_wr_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    idle_mode_t idle_mode = IDLE_NONE;
    logic [EPS_W-1:0] eps_model;
    longint rcv_pt[3];
    longint rcv_nm[3];
    logic [FF_W-1:0] ff_pending[$];
    int mismatches = 0;
    int stall_cycles = 0;
    stim_row_t dir_rows[$];

    disk_occluder_form_factor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic dof_in_t mk_geo(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                       logic [17:0] nx, logic [17:0] ny, logic [17:0] nz,
                                       logic [30:0] rad);
        dof_in_t g;
        g = '0;
        g.pos_x = px;
        g.pos_y = py;
        g.pos_z = pz;
        g.norm_x = nx;
        g.norm_y = ny;
        g.norm_z = nz;
        g.radius = rad;
        return g;
    endfunction

    function automatic logic [FF_W-1:0] disk_ff(dof_in_t g);
        longint d[3];
        longint p[3];
        longint n[3];
        longint t;
        longint big_r;
        longint half;
        longint ddo;
        longint ddn;
        logic [63:0] hp;
        logic [63:0] nn;
        logic [63:0] a;
        logic [127:0] rr;
        logic [127:0] dd;
        logic [127:0] c;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        p[0] = longint'(g.pos_x);
        p[1] = longint'(g.pos_y);
        p[2] = longint'(g.pos_z);
        n[0] = longint'(g.norm_x);
        n[1] = longint'(g.norm_y);
        n[2] = longint'(g.norm_z);
        t = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = p[i] - rcv_pt[i];
            t += d[i] * rcv_nm[i];
        end
        big_r = longint'({33'b0, g.radius}) <<< 16;
        if (t < -big_r)
            return '0;
        if (t < big_r)
        begin
            half = (big_r - t) >>> 17;
            hp = 64'((big_r + t) >>> 17);
            nn = '0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] += (half * rcv_nm[i]) >>> 16;
                nn += 64'(rcv_nm[i] * rcv_nm[i]);
            end
            rr = ((128'(hp) * 128'(hp)) * 128'(nn)) >> 32;
        end
        else
            rr = 128'(g.radius) * 128'(g.radius);
        ddo = 0;
        ddn = 0;
        dd = '0;
        for (int i = 0; i < 3; i++)
        begin
            a = 64'(d[i] < 0 ? -d[i] : d[i]);
            ddo += d[i] * n[i];
            ddn += d[i] * rcv_nm[i];
            dd += 128'(a) * 128'(a);
        end
        if (ddo >= 0 || ddn <= 0 || dd == '0)
            return '0;
        c = (128'(64'(-ddo)) * 128'(64'(ddn))) / dd;
        num = rr * {64'b0, c[63:0]};
        den = (dd + (128'(eps_model) << 16)) << 16;
        q = num / den;
        if (q[127:64] != '0 || c[127:64] != '0 || q[63:0] > 64'(FF_MAX))
            return FF_MAX;
        return q[FF_W-1:0];
    endfunction

    task automatic write_eps(logic [EPS_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        eps_model = v;
    endtask

    task automatic send_item(logic op, dof_in_t g, bit known, logic [FF_W-1:0] ff);
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
        begin
            while ($urandom_range(99) < (idle_mode == IDLE_SEND ? 45 : 10))
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= g;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == OP_LOAD)
        begin
            rcv_pt[0] = longint'(g.pos_x);
            rcv_pt[1] = longint'(g.pos_y);
            rcv_pt[2] = longint'(g.pos_z);
            rcv_nm[0] = longint'(g.norm_x);
            rcv_nm[1] = longint'(g.norm_y);
            rcv_nm[2] = longint'(g.norm_z);
        end
        else
            ff_pending.push_back(known ? ff : disk_ff(g));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ff_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] near_coord(longint base);
        if ($urandom_range(9) == 0)
            return $urandom;
        return 32'(base + longint'($urandom_range(0, 32'h0080_0000)) - 64'sh40_0000);
    endfunction

    function automatic logic [17:0] rand_norm();
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic send_random();
        dof_in_t g;
        logic [30:0] rad;
        if ($urandom_range(9) == 0)
        begin
            g = mk_geo($urandom, $urandom, $urandom, rand_norm(), rand_norm(), rand_norm(),
                       31'($urandom));
            if ($urandom_range(1) == 0)
                g = mk_geo(near_coord(0), near_coord(0), near_coord(0),
                           rand_norm(), rand_norm(), rand_norm(), 31'($urandom));
            send_item(OP_LOAD, g, 1'b0, '0);
        end
        else
        begin
            case ($urandom_range(3))
                0: rad = 31'($urandom);
                1: rad = '0;
                default: rad = 31'($urandom_range(0, 32'h0040_0000));
            endcase
            g = mk_geo(near_coord(rcv_pt[0]), near_coord(rcv_pt[1]), near_coord(rcv_pt[2]),
                       rand_norm(), rand_norm(), rand_norm(), rad);
            send_item(OP_EVAL, g, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        case (idle_mode)
            IDLE_RECV: m_axis_tready <= ($urandom_range(99) >= 45);
            IDLE_BOTH: m_axis_tready <= ($urandom_range(99) >= 10);
            default:   m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        logic [FF_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (ff_pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected form_factor %h", m_axis_tdata);
            end
            else
            begin
                want = ff_pending.pop_front();
                if (m_axis_tdata !== {1'b0, want})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("form_factor mismatch: expected %h got %h", want,
                                 m_axis_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t r;
        logic [EPS_W-1:0] eps_set[4];
        eps_model = EPS_RESET;
        for (int i = 0; i < 3; i++)
        begin
            rcv_pt[i] = 0;
            rcv_nm[i] = 0;
        end
        eps_set = '{16'd1, 16'hFFFF, 16'd0, 16'd1};

        // zero receiver normal after reset
        dir_rows.push_back('{OP_EVAL, mk_geo(32'h10000, 0, 0, 0, 0, 0, 31'h10000), 1'b1, '0});
        dir_rows.push_back('{OP_LOAD, mk_geo(0, 0, 0, 0, 0, 18'h10000, 0), 1'b0, '0});
        dir_rows.push_back('{OP_EVAL, mk_geo(0, 0, 32'h20000, 0, 0, 18'h30000, 31'h10000),
                             1'b0, '0});
        // seen from behind
        dir_rows.push_back('{OP_EVAL, mk_geo(0, 0, 32'h20000, 0, 0, 18'h10000, 31'h10000),
                             1'b1, '0});
        // below tangent plane
        dir_rows.push_back('{OP_EVAL, mk_geo(0, 0, 32'hFFF6_0000, 0, 0, 18'h30000,
                             31'h10000), 1'b1, '0});
        // straddles the horizon
        dir_rows.push_back('{OP_EVAL, mk_geo(32'h4000, 0, 32'h8000, 0, 0, 18'h30000,
                             31'h10000), 1'b0, '0});
        // centre on the receiver
        dir_rows.push_back('{OP_EVAL, mk_geo(0, 0, 0, 0, 0, 18'h30000, 0), 1'b1, '0});
        dir_rows.push_back('{OP_EVAL, mk_geo(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             18'h30000, 18'h10000, 18'h30000, 31'h7FFF_FFFF), 1'b0, '0});
        dir_rows.push_back('{OP_EVAL, mk_geo(0, 0, 32'h1_0000, 0, 0, 18'h30000,
                             31'h7FFF_FFFF), 1'b0, '0});
        // non-unit normals, close occluder
        dir_rows.push_back('{OP_LOAD, mk_geo(0, 0, 0, 18'h10000, 18'h10000, 18'h10000, 0),
                             1'b0, '0});
        dir_rows.push_back('{OP_EVAL, mk_geo(1, 1, 1, 18'h30000, 18'h30000, 18'h30000, 1),
                             1'b0, '0});
        dir_rows.push_back('{OP_EVAL, mk_geo(32'h100, 32'h100, 32'h100,
                             18'h30000, 18'h30000, 18'h30000, 31'h7FFF_FFFF), 1'b0, '0});
        dir_rows.push_back('{OP_LOAD, mk_geo(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             18'h30000, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{OP_EVAL, mk_geo(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             18'h10000, 18'h10000, 18'h10000, 31'h7FFF_FFFF), 1'b0, '0});
        dir_rows.push_back('{OP_LOAD, mk_geo(0, 0, 0, 0, 0, 18'h10000, 0), 1'b0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_mode = idle_mode_t'(ph % 4);
            write_eps(ph < 4 ? eps_set[ph] : EPS_W'($urandom));
            if (ph == 0)
                foreach (dir_rows[i])
                begin
                    r = dir_rows[i];
                    send_item(r.op, r.geo, r.known, r.ff);
                end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random();
            drain();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: sim.f
hdl/dof_pkg.sv
hdl/dof_div.sv
hdl/dof_front.sv
hdl/dof_scale.sv
hdl/disk_occluder_form_factor.sv
bench/tb_top.sv
